// ===== sv/tprav_pkg.sv =====
// Shared types and constants for the tachometer period-to-rpm block.
package tprav_pkg;

    // Width of the capture clock frequency register
    localparam int CLK_W = 28;
    // Width of a speed value, unsigned Q24.8
    localparam int RPM_W = 32;
    // Width of the capture counter
    localparam int CAP_W = 32;
    // Width of clock_hz * 15 * 256 (15 * 256 = 3840 < 2^12)
    localparam int NUM_W = CLK_W + 12;

    localparam logic [CLK_W-1:0] CLOCK_RESET = CLK_W'(120000000);
    localparam logic [RPM_W-1:0] RPM_SAT     = '1;

    // Event kinds
    localparam logic KIND_MEASURE  = 1'b0;
    localparam logic KIND_OVERFLOW = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RPM_DIV,
        ST_UPDATE,
        ST_AVG_START,
        ST_AVG_DIV,
        ST_FINISH
    } seq_state_t;

endpackage

// ===== sv/tprav_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module tprav_div
    import tprav_pkg::*;
#(
    parameter int DVD_W = 40,
    parameter int DVS_W = 41
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic               busy_reg,  busy_next;
    logic               done_reg,  done_next;
    logic [CNT_W-1:0]   cnt_reg,   cnt_next;
    logic [DVS_W-1:0]   rem_reg,   rem_next;
    logic [DVD_W-1:0]   quo_reg,   quo_next;
    logic [DVS_W-1:0]   dvs_reg,   dvs_next;
    logic [DVS_W:0]     shifted;
    logic [DVS_W+1:0]   diff;
    logic               borrow;

    // Shift in the next dividend bit and trial-subtract the divisor
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DVD_W-1]};
        diff    = {1'b0, shifted} - {2'b00, dvs_reg};
        borrow  = diff[DVS_W+1];
    end

    // Sequence the steps
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = borrow ? shifted[DVS_W-1:0] : diff[DVS_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], ~borrow};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/tachometer_period_to_rpm_average_core.sv =====
// Top level: capture events to latest and moving-average rpm.
//
// Input channel (in_valid / in_stall) carries one capture event per request:
// kind 1 is a counter overflow, kind 0 a completed measurement with its
// capture_count. An overflow request is taken while idle and gives no
// result. A measurement request divides 15 * clock_hz * 256 by the period,
// updates the ring of the last WINDOW speeds and a running sum, then divides
// the sum by the number of measurements seen (up to WINDOW). Both divisions
// run on one shared restoring divider, one quotient bit per cycle. in_stall
// is high while a measurement is being worked, so the next request is taken
// only once the result of that measurement has been loaded into the output
// register. Output channel (out_valid / out_stall) presents average_rpm and
// latest_rpm from an output register; a stalled result holds, and the block
// may take overflow requests meanwhile but parks a finished measurement
// until the output register frees. The user must write clock_hz through
// cfg_we / cfg_wdata only while idle; the block itself does not enforce this.
// Reset clears the overflow count, ring, sum and fill count and sets
// clock_hz to 120000000.
module tachometer_period_to_rpm_average_core
    import tprav_pkg::*;
#(
    parameter int WINDOW        = 5,
    parameter int OVERFLOW_BITS = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             kind,
    input  logic [CAP_W-1:0] capture_count,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [RPM_W-1:0] average_rpm,
    output logic [RPM_W-1:0] latest_rpm,
    input  logic             cfg_we,
    input  logic [CLK_W-1:0] cfg_wdata
);

    localparam int PER_W = OVERFLOW_BITS + CAP_W + 1;
    localparam int SUM_W = RPM_W + $clog2(WINDOW);
    localparam int DVD_W = (NUM_W >= SUM_W) ? NUM_W : SUM_W;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int DVS_W = (PER_W >= CNT_W) ? PER_W : CNT_W;
    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    seq_state_t               state_reg, state_next;
    logic [CLK_W-1:0]         clock_hz_reg;
    logic [OVERFLOW_BITS-1:0] ovf_reg,   ovf_next;
    logic [RPM_W-1:0]         ring_reg [WINDOW];
    logic [IDX_W-1:0]         idx_reg,   idx_next;
    logic [CNT_W-1:0]         fill_reg,  fill_next;
    logic [SUM_W-1:0]         sum_reg,   sum_next;
    logic [RPM_W-1:0]         latest_reg, latest_next;
    logic [RPM_W-1:0]         avg_reg,   avg_next;
    logic                     out_valid_reg, out_valid_next;
    logic [RPM_W-1:0]         out_avg_reg, out_avg_next;
    logic [RPM_W-1:0]         out_latest_reg, out_latest_next;
    logic                     ring_we;

    logic                     accept;
    logic [NUM_W-1:0]         num;
    logic [PER_W-1:0]         period;
    logic                     div_start;
    logic [DVD_W-1:0]         div_dividend;
    logic [DVS_W-1:0]         div_divisor;
    logic                     div_done;
    logic [DVD_W-1:0]         div_quotient;

    // Take a request only while idle (in_stall is low exactly then)
    assign accept = in_valid && (state_reg == ST_IDLE);

    // Form 15 * 256 * clock_hz and the period in ticks
    always_comb
    begin
        num    = NUM_W'({clock_hz_reg, 12'b0}) - NUM_W'({clock_hz_reg, 8'b0});
        period = PER_W'({ovf_reg, capture_count}) + PER_W'(1);
    end

    // Feed the shared divider
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = DVD_W'(num);
        div_divisor  = DVS_W'(period);
        if (state_reg == ST_AVG_START)
        begin
            div_start    = 1'b1;
            div_dividend = DVD_W'(sum_reg);
            div_divisor  = DVS_W'(fill_reg);
        end
        else if (accept && kind == KIND_MEASURE)
        begin
            div_start = 1'b1;
        end
    end

    tprav_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Sequence one request and manage the output register
    always_comb
    begin
        state_next      = state_reg;
        in_stall        = 1'b1;
        ovf_next        = ovf_reg;
        idx_next        = idx_reg;
        fill_next       = fill_reg;
        sum_next        = sum_reg;
        latest_next     = latest_reg;
        avg_next        = avg_reg;
        ring_we         = 1'b0;
        out_valid_next  = out_valid_reg;
        out_avg_next    = out_avg_reg;
        out_latest_next = out_latest_reg;

        // Drop a result once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (accept)
                begin
                    if (kind == KIND_OVERFLOW)
                    begin
                        if (ovf_reg != '1)
                        begin
                            ovf_next = ovf_reg + OVERFLOW_BITS'(1);
                        end
                    end
                    else
                    begin
                        ovf_next   = '0;
                        state_next = ST_RPM_DIV;
                    end
                end
            end
            ST_RPM_DIV:
            begin
                if (div_done)
                begin
                    // Saturate the speed to 32 bits
                    if (div_quotient[DVD_W-1:RPM_W] != '0)
                    begin
                        latest_next = RPM_SAT;
                    end
                    else
                    begin
                        latest_next = div_quotient[RPM_W-1:0];
                    end
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                ring_we  = 1'b1;
                sum_next = sum_reg - SUM_W'(ring_reg[idx_reg]) + SUM_W'(latest_reg);
                if (idx_reg == IDX_W'(WINDOW - 1))
                begin
                    idx_next = '0;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
                if (fill_reg != CNT_W'(WINDOW))
                begin
                    fill_next = fill_reg + CNT_W'(1);
                end
                state_next = ST_AVG_START;
            end
            ST_AVG_START:
            begin
                state_next = ST_AVG_DIV;
            end
            ST_AVG_DIV:
            begin
                if (div_done)
                begin
                    avg_next   = div_quotient[RPM_W-1:0];
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // Load the output register once it is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_avg_next    = avg_reg;
                    out_latest_next = latest_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            clock_hz_reg  <= CLOCK_RESET;
            ovf_reg       <= '0;
            idx_reg       <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ovf_reg       <= ovf_next;
            idx_reg       <= idx_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                clock_hz_reg <= cfg_wdata;
            end
        end
    end

    // Hold the speed ring, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                ring_reg[i] <= '0;
            end
        end
        else if (ring_we)
        begin
            ring_reg[idx_reg] <= latest_reg;
        end
    end

    // Hold results
    always_ff @(posedge clk)
    begin
        latest_reg     <= latest_next;
        avg_reg        <= avg_next;
        out_avg_reg    <= out_avg_next;
        out_latest_reg <= out_latest_next;
    end

    assign out_valid   = out_valid_reg;
    assign average_rpm = out_avg_reg;
    assign latest_rpm  = out_latest_reg;

endmodule
